// ----- rtl/shk_pkg.sv -----
package shk_pkg;

    localparam int NUM_ROUNDS = 80;
    localparam int ROUND_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 2'd1;

    typedef logic [31:0] t_word;
    typedef logic [15:0][31:0] t_sched;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_state;

    localparam t_word H0 = 32'h6745_2301;
    localparam t_word H1 = 32'hEFCD_AB89;
    localparam t_word H2 = 32'h98BA_DCFE;
    localparam t_word H3 = 32'h1032_5476;
    localparam t_word H4 = 32'hC3D2_E1F0;

    localparam t_word K0 = 32'h5A82_7999;
    localparam t_word K1 = 32'h6ED9_EBA1;
    localparam t_word K2 = 32'h8F1B_BCDC;
    localparam t_word K3 = 32'hCA62_C1D6;

    // padding words of the single block: 0x80 marker, length 192 bits
    localparam t_word PAD_MARK = 32'h8000_0000;
    localparam t_word PAD_LEN  = 32'h0000_00C0;

    function automatic t_word f_bswap32(input t_word x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic t_word f_round_f(input logic [ROUND_W-1:0] t,
                                        input t_word b, input t_word c,
                                        input t_word d);
        if (t < ROUND_W'(20)) begin
            return (b & c) | (~b & d);
        end else if (t < ROUND_W'(40)) begin
            return b ^ c ^ d;
        end else if (t < ROUND_W'(60)) begin
            return (b & c) | (b & d) | (c & d);
        end else begin
            return b ^ c ^ d;
        end
    endfunction

    function automatic t_word f_round_k(input logic [ROUND_W-1:0] t);
        if (t < ROUND_W'(20)) begin
            return K0;
        end else if (t < ROUND_W'(40)) begin
            return K1;
        end else if (t < ROUND_W'(60)) begin
            return K2;
        end else begin
            return K3;
        end
    endfunction

endpackage

// ----- rtl/shk_round.sv -----
module shk_round import shk_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [ROUND_W-1:0]  i_round,
    input  logic                i_valid,
    input  t_state              i_state,
    input  t_sched              i_sched,
    output logic                o_valid,
    output t_state              o_state,
    output t_sched              o_sched
);

    logic   r_valid;
    t_state r_state;
    t_sched r_sched;
    t_state n_state;
    t_sched n_sched;
    t_word  w_next;

    always_comb begin
        n_state.a = {i_state.a[26:0], i_state.a[31:27]}
                  + f_round_f(i_round, i_state.b, i_state.c, i_state.d)
                  + i_state.e + f_round_k(i_round) + i_sched[0];
        n_state.b = i_state.a;
        n_state.c = {i_state.b[1:0], i_state.b[31:2]};
        n_state.d = i_state.c;
        n_state.e = i_state.d;
    end

    // slide the schedule window and append the next expanded word
    assign w_next = i_sched[13] ^ i_sched[8] ^ i_sched[2] ^ i_sched[0];

    always_comb begin
        for (int i = 0; i < 15; i++) begin
            n_sched[i] = i_sched[i+1];
        end
        n_sched[15] = {w_next[30:0], w_next[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_sched <= n_sched;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_sched = r_sched;

endmodule

// ----- rtl/shk_final.sv -----
module shk_final import shk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_state      i_state,
    output logic        o_valid,
    output logic [63:0] o_position
);

    logic        r_valid;
    logic [63:0] r_position;
    t_word       w_h0;
    t_word       w_h1;

    assign w_h0 = H0 + i_state.a;
    assign w_h1 = H1 + i_state.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // digest bytes read little-endian
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_position <= {f_bswap32(w_h1), f_bswap32(w_h0)};
        end
    end

    assign o_valid    = r_valid;
    assign o_position = r_position;

endmodule

// ----- rtl/sha1_keyed_position_hash_unit.sv -----
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_element [63:0]
// result    out        o_out_valid / i_out_stall  o_position [63:0]
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One request enters per cycle while the result is not stalled; it passes through
// the 80 SHA-1 round stages, one round each, and then the output register.
// Reset clears the valid bits of every stage and both nonce registers.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module sha1_keyed_position_hash_unit import shk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [63:0]           i_element,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [63:0]           o_position,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [63:0] r_nonce_low;
    logic [63:0] r_nonce_high;
    logic        w_en;
    logic        w_vld [0:NUM_ROUNDS];
    t_state      w_st  [0:NUM_ROUNDS];
    t_sched      w_sch [0:NUM_ROUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonce_low  <= '0;
            r_nonce_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold every stage while the result is waiting
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    assign w_vld[0] = i_in_valid;
    assign w_st[0]  = '{a: H0, b: H1, c: H2, d: H3, e: H4};

    always_comb begin
        w_sch[0]     = '0;
        w_sch[0][0]  = f_bswap32(i_element[31:0]);
        w_sch[0][1]  = f_bswap32(i_element[63:32]);
        w_sch[0][2]  = f_bswap32(r_nonce_low[31:0]);
        w_sch[0][3]  = f_bswap32(r_nonce_low[63:32]);
        w_sch[0][4]  = f_bswap32(r_nonce_high[31:0]);
        w_sch[0][5]  = f_bswap32(r_nonce_high[63:32]);
        w_sch[0][6]  = PAD_MARK;
        w_sch[0][15] = PAD_LEN;
    end

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        shk_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_round (ROUND_W'(g)),
            .i_valid (w_vld[g]),
            .i_state (w_st[g]),
            .i_sched (w_sch[g]),
            .o_valid (w_vld[g+1]),
            .o_state (w_st[g+1]),
            .o_sched (w_sch[g+1])
        );
    end

    shk_final u_final (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_vld[NUM_ROUNDS]),
        .i_state    (w_st[NUM_ROUNDS]),
        .o_valid    (o_out_valid),
        .o_position (o_position)
    );

`ifndef ASSERT_OFF
    a_stall_only_on_blocked_result: assert property (@(posedge i_clk)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("request stall without a blocked result");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_last_round_reaches_output: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (w_vld[NUM_ROUNDS] && w_en) |=> o_out_valid)
        else $error("final round request lost before output");
`endif

endmodule

// ----- sim/sha1_keyed_position_hash_checker.sv -----
`timescale 1ns / 1ps

module sha1_keyed_position_hash_checker import shk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [63:0]           i_element,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [63:0]           i_position,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [31:0] INIT_A = 32'h6745_2301;
    localparam logic [31:0] INIT_B = 32'hEFCD_AB89;
    localparam logic [31:0] INIT_C = 32'h98BA_DCFE;
    localparam logic [31:0] INIT_D = 32'h1032_5476;
    localparam logic [31:0] INIT_E = 32'hC3D2_E1F0;

    localparam logic [31:0] MIX_K0 = 32'h5A82_7999;
    localparam logic [31:0] MIX_K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] MIX_K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] MIX_K3 = 32'hCA62_C1D6;

    logic [63:0] nonce_lo;
    logic [63:0] nonce_hi;
    logic [63:0] expected_positions [$];
    int          mismatch_count;
    int          waiting_count;

    assign o_fail_count = mismatch_count;
    assign o_pending    = waiting_count;

    function automatic logic [31:0] swap_bytes(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // SHA-1 over element | nonce_low | nonce_high (24 bytes, little-endian each)
    function automatic logic [63:0] hash_position(input logic [63:0] element,
                                                  input logic [63:0] lo,
                                                  input logic [63:0] hi);
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, tmp, x;
        int          t;
        for (t = 0; t < 16; t++) begin
            w[t] = 32'h0;
        end
        w[0]  = swap_bytes(element[31:0]);
        w[1]  = swap_bytes(element[63:32]);
        w[2]  = swap_bytes(lo[31:0]);
        w[3]  = swap_bytes(lo[63:32]);
        w[4]  = swap_bytes(hi[31:0]);
        w[5]  = swap_bytes(hi[63:32]);
        w[6]  = 32'h8000_0000;
        w[15] = 32'h0000_00C0;
        for (t = 16; t < 80; t++) begin
            x    = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
            w[t] = {x[30:0], x[31]};
        end
        a = INIT_A;
        b = INIT_B;
        c = INIT_C;
        d = INIT_D;
        e = INIT_E;
        for (t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = MIX_K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = MIX_K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = MIX_K2;
            end else begin
                f = b ^ c ^ d;
                k = MIX_K3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t];
            e   = d;
            d   = c;
            c   = {b[1:0], b[31:2]};
            b   = a;
            a   = tmp;
        end
        a = a + INIT_A;
        b = b + INIT_B;
        // first eight digest bytes, first byte least significant
        return {swap_bytes(b), swap_bytes(a)};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got %016h, expected %016h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    initial begin
        mismatch_count = 0;
        waiting_count  = 0;
        nonce_lo       = '0;
        nonce_hi       = '0;
    end

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            nonce_lo = '0;
            nonce_hi = '0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_positions.push_back(hash_position(i_element, nonce_lo, nonce_hi));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_positions.size() == 0) begin
                    report_mismatch("position with no request outstanding", i_position, '0);
                end else begin
                    want = expected_positions.pop_front();
                    if (i_position !== want) begin
                        report_mismatch("position", i_position, want);
                    end
                end
            end
            // out-of-range indexes leave both halves alone
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NONCE_LOW: begin
                        nonce_lo = i_cfg_data;
                    end
                    CFG_NONCE_HIGH: begin
                        nonce_hi = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            waiting_count = expected_positions.size();
        end
    end

endmodule

// ----- sim/sha1_keyed_position_hash_unit_tb.sv -----
`timescale 1ns / 1ps

module sha1_keyed_position_hash_unit_tb import shk_pkg::*;;

    localparam int PIPE_LATENCY   = 81;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 275;
    localparam int HOLD_CYCLES    = 400;

    // indexes past the two nonce halves; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [63:0]           element   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [63:0]           position;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    bit idle_bursts = 1'b1;
    int hold_left   = 0;

    logic [63:0] corner_elements [12] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h0123_4567_89AB_CDEF, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555, 64'h0000_0000_FFFF_FFFF,
        64'hFFFF_FFFF_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
        64'hFEDC_BA98_7654_3210, 64'h00FF_00FF_00FF_00FF
    };

    always #6 clk = ~clk;

    sha1_keyed_position_hash_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_element   (element),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_position  (position),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sha1_keyed_position_hash_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_element    (element),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_position   (position),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [63:0] pick_element();
        int bit_pos;
        bit_pos = $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << bit_pos;
            3: return ~(64'h1 << bit_pos);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_element(input logic [63:0] value);
        int gap;
        @(negedge clk);
        if (idle_bursts && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        element  <= value;
        // hold the request until the block takes it
        do begin
            @(posedge clk);
        end while (in_stall);
    endtask

    task automatic drop_request();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        do begin
            @(negedge clk);
        end while (pending != 0);
    endtask

    // receiver: random stall bursts plus one long hold-off when asked
    initial begin : receiver
        int burst_left;
        burst_left = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (burst_left > 0) begin
                out_stall <= 1'b1;
                burst_left--;
            end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int          p;
        int          n;
        logic [63:0] lo;
        logic [63:0] hi;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset nonce of zero
        for (n = 0; n < 12; n++) begin
            send_element(corner_elements[n]);
        end
        drop_request();
        wait_for_results();

        write_reg(CFG_NONCE_LOW, '1);
        write_reg(CFG_NONCE_HIGH, '1);
        send_element(64'h0);
        send_element('1);
        send_element(64'h0123_4567_89AB_CDEF);
        drop_request();
        wait_for_results();

        write_reg(CFG_NONCE_LOW, 64'h0F1E_2D3C_4B5A_6978);
        write_reg(CFG_NONCE_HIGH, 64'h0);
        send_element(64'h0);
        send_element(64'h8000_0000_0000_0001);
        drop_request();
        wait_for_results();

        // spare indexes: the nonce must stay as it was
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, 64'hDEAD_BEEF_CAFE_F00D);
        send_element(64'h0);
        send_element('1);
        send_element(64'h0123_4567_89AB_CDEF);
        drop_request();
        wait_for_results();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    lo = '0;
                    hi = '1;
                end
                1: begin
                    lo = '1;
                    hi = '0;
                end
                4: begin
                    lo = 64'h1 << $urandom_range(0, 63);
                    hi = ~(64'h1 << $urandom_range(0, 63));
                end
                default: begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
            endcase
            write_reg(CFG_NONCE_LOW, lo);
            write_reg(CFG_NONCE_HIGH, hi);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(2, 3)), {$urandom, $urandom});
            end
            idle_bursts = (p != RANDOM_PHASES - 1);
            // long hold-off so the pipeline fills and stalls its input
            if (p == 2) begin
                hold_left = HOLD_CYCLES;
            end
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                send_element(pick_element());
            end
            drop_request();
            wait_for_results();
        end

        repeat (PIPE_LATENCY + 10) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sha1_keyed_position_hash_unit.f -----
rtl/shk_pkg.sv
rtl/shk_round.sv
rtl/shk_final.sv
rtl/sha1_keyed_position_hash_unit.sv
sim/sha1_keyed_position_hash_checker.sv
sim/sha1_keyed_position_hash_unit_tb.sv
